### rtl/dap_pkg.sv
// Shared types and constants for the decimal text to integer parser.
// No dependencies; every other file of the block imports this package.
package dap_pkg;

	localparam int unsigned CH_W     = 8;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 2;

	// Characters of interest.
	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

	// Largest magnitude that may still be multiplied by ten.
	localparam logic [VALUE_W-1:0] LIM_32 = 32'd214748364;
	localparam logic [VALUE_W-1:0] LIM_16 = 32'd3276;
	localparam logic [VALUE_W-1:0] MAX_32 = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] MAX_16 = 32'h0000_7FFF;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_WARN   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_SYNTAX = 2'd3;

	// Compatibility modes; any other code behaves as the third mode.
	localparam logic [MODE_W-1:0] MODE_STRICT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LENIENT = 2'd1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMPAT_MODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATE     = 2'd2;

	typedef struct packed {
		logic              result_width;
		logic [MODE_W-1:0] compat_mode;
		logic              saturate;
	} cfg_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [STATUS_W-1:0]       status;
	} res_t;

endpackage

### rtl/dap_if.sv
// Valid/ready channel interfaces for the parser: byte input and result output.
// Depends on dap_pkg for field widths.
interface dap_in_if import dap_pkg::*;;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] ch;

	modport source(output valid, output ch, input ready);
	modport sink(input valid, input ch, output ready);
endinterface

interface dap_out_if import dap_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic [STATUS_W-1:0]       status;

	modport source(output valid, output value, output status, input ready);
	modport sink(input valid, input value, input status, output ready);
endinterface

### rtl/dap_parser.sv
// Parse state and per-byte update logic: whitespace, sign, digit accumulation
// with overflow check, trailing handling and the result at the NUL byte. Uses dap_pkg.
module dap_parser import dap_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [CH_W-1:0] ch,
	input  cfg_t            cfg,
	output res_t            res
);

	typedef enum logic [2:0] {
		PH_LEADING,
		PH_AFTER_SIGN,
		PH_DIGITS,
		PH_TRAILING,
		PH_IGNORE
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [VALUE_W-1:0]  accum_q, accum_d;
	logic                negative_q, negative_d;
	logic                decided_q, decided_d;
	logic [STATUS_W-1:0] dstatus_q, dstatus_d;

	logic               is_ws, is_dig;
	logic [3:0]         dig;
	logic [VALUE_W-1:0] max_pos, lim, acc_x10, sat_value;
	logic               mag_over;

	assign is_ws   = (ch >= CH_TAB && ch <= CH_CR) || ch == CH_SPACE;
	assign is_dig  = ch >= CH_ZERO && ch <= CH_NINE;
	assign dig     = ch[3:0];
	assign max_pos = cfg.result_width ? MAX_32 : MAX_16;
	assign lim     = cfg.result_width ? LIM_32 : LIM_16;
	// Times ten as two shifted adds, plus the new digit.
	assign acc_x10 = {accum_q[VALUE_W-4:0], 3'b000} + {accum_q[VALUE_W-2:0], 1'b0}
		+ {{(VALUE_W-4){1'b0}}, dig};
	// The negative limit is one more than the positive one: -(max+1) is ~max.
	assign sat_value = negative_q ? ~max_pos : max_pos;
	assign mag_over  = negative_q ? (accum_q > max_pos + 32'd1) : (accum_q > max_pos);

	always_comb begin
		logic first, digits, trail;
		first  = 1'b0;
		digits = 1'b0;
		trail  = 1'b0;
		phase_d    = phase_q;
		accum_d    = accum_q;
		negative_d = negative_q;
		decided_d  = decided_q;
		dstatus_d  = dstatus_q;
		if (ch != CH_NUL) begin
			if (!decided_q) begin
				case (phase_q)
					PH_LEADING: begin
						if (is_ws) begin
						end else if (ch == CH_MINUS) begin
							negative_d = 1'b1;
							phase_d    = PH_AFTER_SIGN;
						end else if (ch == CH_PLUS) begin
							phase_d = PH_AFTER_SIGN;
						end else begin
							first = 1'b1;
						end
					end
					PH_AFTER_SIGN: first  = 1'b1;
					PH_DIGITS:     digits = 1'b1;
					PH_TRAILING:   trail  = 1'b1;
					default: ;
				endcase
			end
			// First character after whitespace and sign.
			if (first) begin
				if (is_dig) begin
					digits = 1'b1;
				end else if (cfg.compat_mode == MODE_STRICT) begin
					decided_d = 1'b1;
					dstatus_d = ST_SYNTAX;
				end else if (cfg.compat_mode == MODE_LENIENT) begin
					decided_d = 1'b1;
					dstatus_d = ST_OK;
				end else begin
					trail = 1'b1;
				end
			end
			if (digits) begin
				if (is_dig) begin
					phase_d = PH_DIGITS;
					if (accum_q > lim) begin
						decided_d = 1'b1;
						dstatus_d = cfg.saturate ? ST_WARN : ST_RANGE;
					end else begin
						accum_d = acc_x10;
					end
				end else begin
					trail = 1'b1;
				end
			end
			if (trail) begin
				if (is_ws) begin
					phase_d = PH_TRAILING;
				end else if (cfg.compat_mode == MODE_LENIENT) begin
					phase_d = PH_IGNORE;
				end else begin
					decided_d = 1'b1;
					dstatus_d = ST_SYNTAX;
				end
			end
		end else begin
			// The terminator returns the parse state to its start.
			phase_d    = PH_LEADING;
			accum_d    = '0;
			negative_d = 1'b0;
			decided_d  = 1'b0;
			dstatus_d  = ST_OK;
		end
	end

	// Result for a terminator arriving in the current state.
	always_comb begin
		logic                d;
		logic [STATUS_W-1:0] ds;
		d  = decided_q;
		ds = dstatus_q;
		res.value  = '0;
		res.status = ST_OK;
		if (!d && (phase_q == PH_LEADING || phase_q == PH_AFTER_SIGN)) begin
			d  = 1'b1;
			ds = (cfg.compat_mode == MODE_STRICT) ? ST_SYNTAX : ST_OK;
		end
		if (!d && mag_over) begin
			d  = 1'b1;
			ds = cfg.saturate ? ST_WARN : ST_RANGE;
		end
		if (d) begin
			res.status = ds;
			res.value  = (ds == ST_WARN) ? sat_value : '0;
		end else begin
			res.value = negative_q ? (32'd0 - accum_q) : accum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEADING;
			accum_q    <= '0;
			negative_q <= 1'b0;
			decided_q  <= 1'b0;
			dstatus_q  <= ST_OK;
		end else if (step) begin
			phase_q    <= phase_d;
			accum_q    <= accum_d;
			negative_q <= negative_d;
			decided_q  <= decided_d;
			dstatus_q  <= dstatus_d;
		end
	end

endmodule

### rtl/decimal_ascii_to_int_parser.sv
// Top level of the decimal text to integer parser: input stage, configuration
// registers, result register. Uses dap_pkg, dap_if and dap_parser.
//
// Usage: string bytes arrive one per beat on byte_in; a zero byte ends the
// string. Every non-zero byte updates the parse state and yields nothing;
// the zero byte yields one beat on result carrying the signed value and a
// status (ok, saturated, range error, syntax error).
// Bytes are registered in an input stage and then folded into the parse
// state from there, so one byte per clock is sustained unless a terminator
// is held in the input stage. The limit is the single times-ten accumulate
// between the input stage and the parse state. A result is registered in
// the result register once its terminating byte leaves the input stage,
// and stays there until the receiver takes it.
// Configuration is written through cfg_we, cfg_idx and cfg_data (index 0 result width, 1 compatibility
// mode, 2 saturate on overflow); the user must write it only while the block is idle, which it does not enforce.
// When the receiver stalls, non-zero bytes keep flowing because they produce no
// result; only a terminator waiting behind an untaken result holds the input
// stage, and byte_in.ready drops. The result register and the input stage
// together let the next string be accepted while a result waits.
// Reset clears the parse state, the pipeline valids and the configuration
// (32-bit results, strict mode, range errors on overflow).
module decimal_ascii_to_int_parser import dap_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	dap_in_if.sink                byte_in,
	dap_out_if.source             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t            cfg_q;
	logic            valid_s1;
	logic [CH_W-1:0] ch_s1;
	logic            res_valid_q;
	res_t            res_q;
	res_t            res_d;
	logic            advance;
	logic            is_term;

	// Configuration registers; a write to an unused index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.result_width <= 1'b1;
			cfg_q.compat_mode  <= MODE_STRICT;
			cfg_q.saturate     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RESULT_WIDTH: cfg_q.result_width <= cfg_data[0];
				REG_COMPAT_MODE:  cfg_q.compat_mode  <= cfg_data;
				REG_SATURATE:     cfg_q.saturate     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A non-terminator always moves on; a terminator needs a free result slot.
	assign is_term       = ch_s1 == CH_NUL;
	assign advance       = valid_s1 && (!is_term || !res_valid_q || result.ready);
	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			ch_s1 <= byte_in.ch;
		end
	end

	dap_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ch     (ch_s1),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && is_term) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_term) begin
			res_q <= res_d;
		end
	end

	assign result.valid  = res_valid_q;
	assign result.value  = res_q.value;
	assign result.status = res_q.status;

	// A byte other than the terminator never waits in the input stage.
	a_nonterm_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !is_term |-> byte_in.ready)
		else $error("non-terminator byte held in input stage");

	// A terminator behind an untaken result must hold the input stage.
	a_term_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && is_term && res_valid_q && !result.ready |-> !advance)
		else $error("terminator advanced over a pending result");

	// A new result only ever follows a terminator in the input stage.
	a_rise_from_term: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1 && is_term))
		else $error("result appeared without a terminator");

	// A saturated result carries one of the four limit values.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status == ST_WARN |->
		res_q.value == 32'sh7FFF_FFFF || res_q.value == 32'sh8000_0000 ||
		res_q.value == 32'sh0000_7FFF || res_q.value == 32'shFFFF_8000)
		else $error("saturated value is not a type limit");

	// Error results carry a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.status == ST_RANGE || res_q.status == ST_SYNTAX) |->
		res_q.value == 32'sd0)
		else $error("error result with non-zero value");

endmodule
